>>> hw/rtl/capped_least_loaded_dispatcher_macros.svh
// Assertion macros for the capped least-loaded dispatcher.
// Used by the top level; expects clk and rst_n in scope.
`ifndef CAPPED_LEAST_LOADED_DISPATCHER_MACROS_SVH
`define CAPPED_LEAST_LOADED_DISPATCHER_MACROS_SVH

// same-cycle implication, quiet during reset
`define CLLD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define CLLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/clld_pkg.sv
// Shared types and constants for the capped least-loaded dispatcher.
// No dependencies.
package clld_pkg;

  localparam int MAX_NODES_DEF   = 8;
  localparam int COUNT_WIDTH_DEF = 4;
  localparam int NODE_LIMIT      = 8;
  localparam int NODE_W          = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 4;
  localparam int IN_TDATA_W      = 8;
  localparam int OUT_TDATA_W     = 8;

  typedef enum logic {
    CMD_ASSIGN = 1'b0,
    CMD_DONE   = 1'b1
  } cmd_t;

  typedef enum logic {
    POLICY_FIRST_FIT    = 1'b0,
    POLICY_LEAST_LOADED = 1'b1
  } policy_t;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODES_USE = 2'd2;

  localparam policy_t         POLICY_RST  = POLICY_LEAST_LOADED;
  localparam logic [3:0]      MAX_OUT_RST = 4'd2;
  localparam logic [3:0]      NODES_RST   = 4'd3;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] node;
  } pick_t;

endpackage

>>> hw/rtl/clld_pick.sv
// Node selection: first fit or least loaded among nodes below the cap.
// Depends on clld_pkg.
module clld_pick #(
  parameter int NODES       = clld_pkg::NODE_LIMIT,
  parameter int COUNT_WIDTH = clld_pkg::COUNT_WIDTH_DEF
) (
  input  clld_pkg::policy_t                   policy,
  input  logic [3:0]                          max_out,
  input  logic [3:0]                          nodes_use,
  input  logic [NODES-1:0][COUNT_WIDTH-1:0]   counts,
  output clld_pkg::pick_t                     pick
);
  import clld_pkg::*;

  localparam int CMPW = (COUNT_WIDTH > 4) ? COUNT_WIDTH : 4;

  logic [NODES-1:0]       elig;
  logic [COUNT_WIDTH-1:0] best;

  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      elig[i] = (4'(i) < nodes_use) && !(&counts[i]) &&
                (CMPW'(counts[i]) < CMPW'(max_out));
    end
  end

  always_comb begin
    pick = '0;
    best = '0;
    for (int i = 0; i < NODES; i++) begin
      if (elig[i] && (!pick.found ||
          (policy == POLICY_LEAST_LOADED && counts[i] < best))) begin
        pick.found = 1'b1;
        pick.node  = NODE_W'(i);
        best       = counts[i];
      end
    end
  end

endmodule

>>> hw/rtl/capped_least_loaded_dispatcher.sv
// Pipeline: an accepted item waits in the input register; the result register loads
// from it once the output register is empty or being read.
// Throughput: one item per cycle unless the output is stalled; the selection is one
// pass over at most eight counters between the input register and the result register.
// Reset: rst_n synchronous, active low; counters and valid flags clear, config registers take defaults.
// Depends on clld_pkg, clld_pick and capped_least_loaded_dispatcher_macros.svh.
`include "capped_least_loaded_dispatcher_macros.svh"
module capped_least_loaded_dispatcher #(
  parameter int MAX_NODES   = clld_pkg::MAX_NODES_DEF,
  parameter int COUNT_WIDTH = clld_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [clld_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [clld_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [clld_pkg::IN_TDATA_W-1:0]     in_tdata,  // [2:0] done_node
  input  logic                                in_tuser,  // [0] command
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] granted, [3:1] chosen_node, [4] underflow_error
  output logic [clld_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import clld_pkg::*;

  localparam int NODES = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;

  policy_t    policy_r;
  logic [3:0] max_out_r;
  logic [3:0] nodes_use_r;

  logic              s1_v_r;
  cmd_t              s1_cmd_r;
  logic [NODE_W-1:0] s1_node_r;

  logic                             out_v_r;
  logic [OUT_TDATA_W-1:0]           out_data_r;
  logic [OUT_TDATA_W-1:0]           out_data_nxt;
  logic [NODES-1:0][COUNT_WIDTH-1:0] cnt_r;
  logic [NODES-1:0][COUNT_WIDTH-1:0] cnt_nxt;

  pick_t            pick;
  logic             adv;
  logic             in_range;
  logic             underflow;
  logic             granted;

  assign cfg_ready  = 1'b1;
  assign adv        = s1_v_r && (!out_v_r || out_tready);
  assign in_tready  = !s1_v_r || adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POLICY_RST;
      max_out_r   <= MAX_OUT_RST;
      nodes_use_r <= NODES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POLICY:    policy_r    <= policy_t'(cfg_data[0]);
        CFG_MAX_OUT:   max_out_r   <= cfg_data;
        CFG_NODES_USE: nodes_use_r <= cfg_data;
        default: ;
      endcase
    end
  end

  clld_pick #(
    .NODES       (NODES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_pick (
    .policy    (policy_r),
    .max_out   (max_out_r),
    .nodes_use (nodes_use_r),
    .counts    (cnt_r),
    .pick      (pick)
  );

  always_comb begin
    in_range  = ({1'b0, s1_node_r} < (NODE_W + 1)'(NODES));
    granted   = (s1_cmd_r == CMD_ASSIGN) && pick.found;
    underflow = 1'b0;
    cnt_nxt   = cnt_r;
    for (int i = 0; i < NODES; i++) begin
      if (s1_cmd_r == CMD_DONE && in_range && s1_node_r == NODE_W'(i)) begin
        if (cnt_r[i] == '0) begin
          underflow = 1'b1;
        end else begin
          cnt_nxt[i] = cnt_r[i] - 1'b1;
        end
      end
      if (granted && pick.node == NODE_W'(i)) begin
        cnt_nxt[i] = cnt_r[i] + 1'b1;
      end
    end
    out_data_nxt      = '0;
    out_data_nxt[0]   = granted;
    out_data_nxt[3:1] = granted ? pick.node : '0;
    out_data_nxt[4]   = underflow;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
        cnt_r   <= cnt_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r  <= cmd_t'(in_tuser);
      s1_node_r <= in_tdata[NODE_W-1:0];
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  `CLLD_ASSERT_NOW(a_refuse_zero, out_v_r && !out_data_r[0],
    out_data_r[3:1] == '0, "refusal with node")
  `CLLD_ASSERT_NOW(a_grant_in_use, out_v_r && out_data_r[0],
    {1'b0, out_data_r[3:1]} < nodes_use_r, "grant beyond nodes in use")
  `CLLD_ASSERT_NOW(a_stall_full, !in_tready,
    s1_v_r && out_v_r && !out_tready, "input stalled without back-pressure")
  `CLLD_ASSERT_NEXT(a_adv_result, adv, out_v_r, "advanced item lost")

endmodule

>>> tb/tb.sv
// Self-checking testbench for capped_least_loaded_dispatcher: directed and random
// assign and completion transfers, checked against an in-bench model of the node loads.
// Depends on clld_pkg and the dispatcher RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clld_pkg::*;

  localparam int LONG_HOLD = 200;

  typedef struct {
    logic              granted;
    logic [NODE_W-1:0] node;
    logic              underflow;
  } dispatch_res_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [2:0] done_node
  logic                   in_tuser;   // [0] command
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [0] granted, [3:1] chosen_node, [4] underflow_error

  // model of the block
  logic [3:0]      node_load [MAX_NODES_DEF];
  policy_t         mode_r;
  logic [3:0]      cap_r;
  logic [3:0]      nodes_r;
  dispatch_res_t   dispatch_q[$];

  int mismatch_cnt;
  bit rx_stall_en;
  bit hold_off_req;

  capped_least_loaded_dispatcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic dispatch_res_t pick_and_update(input cmd_t cmd,
                                                    input logic [NODE_W-1:0] node);
    dispatch_res_t res;
    int            n;
    bit            found;
    int            best;
    int            pick;
    res.granted   = 1'b0;
    res.node      = '0;
    res.underflow = 1'b0;
    found = 0;
    best  = 0;
    pick  = 0;
    if (cmd == CMD_ASSIGN) begin
      n = (nodes_r > MAX_NODES_DEF) ? MAX_NODES_DEF : nodes_r;
      for (int i = 0; i < n; i++) begin
        if (node_load[i] < cap_r) begin
          if (!found || (mode_r == POLICY_LEAST_LOADED && node_load[i] < best)) begin
            found = 1;
            best  = node_load[i];
            pick  = i;
            if (mode_r == POLICY_FIRST_FIT) break;
          end
        end
      end
      if (found) begin
        node_load[pick] = node_load[pick] + 4'd1;
        res.granted     = 1'b1;
        res.node        = pick[NODE_W-1:0];
      end
    end else if (node_load[node] == 4'd0) begin
      res.underflow = 1'b1;
    end else begin
      node_load[node] = node_load[node] - 4'd1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    dispatch_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (dispatch_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 8'h00);
      end else begin
        want = dispatch_q.pop_front();
        if (out_tdata[0] !== want.granted)
          report_mismatch("granted", {7'b0, out_tdata[0]}, {7'b0, want.granted});
        if (out_tdata[3:1] !== want.node)
          report_mismatch("chosen_node", {5'b0, out_tdata[3:1]}, {5'b0, want.node});
        if (out_tdata[4] !== want.underflow)
          report_mismatch("underflow_error", {7'b0, out_tdata[4]}, {7'b0, want.underflow});
        if (out_tdata[7:5] !== 3'b000)
          report_mismatch("tdata padding", {5'b0, out_tdata[7:5]}, 8'h00);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready  <= 1'b0;
        hold_off_req = 0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (rx_stall_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // all drive tasks start and end on a falling edge
  task automatic send_item(input cmd_t cmd, input logic [NODE_W-1:0] node);
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W - NODE_W){1'b0}}, node};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    dispatch_q.insert(dispatch_q.size(), pick_and_update(cmd, node));
    @(negedge clk);
  endtask

  task automatic idle_input(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (dispatch_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_POLICY:    mode_r  = policy_t'(val[0]);
      CFG_MAX_OUT:   cap_r   = val;
      CFG_NODES_USE: nodes_r = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input policy_t pol, input logic [3:0] cap, input logic [3:0] nodes);
    write_reg(CFG_POLICY, {3'b000, pol});
    write_reg(CFG_MAX_OUT, cap);
    write_reg(CFG_NODES_USE, nodes);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int assign_pct, input bit gaps);
    cmd_t              cmd;
    logic [NODE_W-1:0] node;
    cmd  = ($urandom_range(0, 99) < assign_pct) ? CMD_ASSIGN : CMD_DONE;
    node = $urandom_range(0, 7);
    send_item(cmd, node);
    if (gaps && $urandom_range(0, 7) == 0) idle_input($urandom_range(1, 18));
  endtask

  // reset values: least loaded over three nodes, cap of two
  task automatic test_reset_defaults();
    repeat (7) send_item(CMD_ASSIGN, 3'd0);
    send_item(CMD_DONE, 3'd7);
    send_item(CMD_DONE, 3'd5);
    send_item(CMD_DONE, 3'd0);
  endtask

  task automatic test_zero_settings();
    drain();
    set_config(POLICY_FIRST_FIT, 4'd0, 4'd8);
    send_item(CMD_ASSIGN, 3'd0);
    drain();
    set_config(POLICY_FIRST_FIT, 4'd15, 4'd0);
    send_item(CMD_ASSIGN, 3'd7);
  endtask

  // first fit piles onto node 0; node count above range clamps to eight
  task automatic test_first_fit_full_range();
    drain();
    set_config(POLICY_FIRST_FIT, 4'd15, 4'd15);
    repeat (6) send_item(CMD_ASSIGN, 3'd0);
  endtask

  // counts above a lowered cap stay and are skipped
  task automatic test_lowered_cap();
    drain();
    set_config(POLICY_LEAST_LOADED, 4'd1, 4'd8);
    repeat (3) send_item(CMD_ASSIGN, 3'd0);
    send_item(CMD_DONE, 3'd0);
    send_item(CMD_DONE, 3'd2);
  endtask

  task automatic test_random_phases(input int phases, input int per_phase);
    policy_t    pol;
    logic [3:0] cap;
    logic [3:0] nodes;
    int         pct;
    bit         gaps;
    for (int p = 0; p < phases; p++) begin
      drain();
      pol   = policy_t'($urandom_range(0, 1));
      cap   = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
      nodes = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
      if (p == 0) begin
        cap   = 4'd15;
        nodes = 4'd8;
      end else if (p == 1) begin
        cap   = 4'd1;
        nodes = 4'd1;
      end
      set_config(pol, cap, nodes);
      case ($urandom_range(0, 2))
        0:       pct = 25;
        1:       pct = 50;
        default: pct = 75;
      endcase
      gaps        = ($urandom_range(0, 3) != 0);
      rx_stall_en = gaps;
      repeat (per_phase) send_random(pct, gaps);
    end
  endtask

  task automatic test_backpressure();
    drain();
    set_config(POLICY_LEAST_LOADED, 4'd3, 4'd4);
    rx_stall_en  = 0;
    hold_off_req = 1;
    repeat (50) send_random(60, 1'b0);
  endtask

  task automatic test_full_rate();
    drain();
    set_config(POLICY_LEAST_LOADED, 4'd4, 4'd6);
    rx_stall_en = 0;
    repeat (140) send_random(55, 1'b0);
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    mismatch_cnt = 0;
    rx_stall_en  = 0;
    hold_off_req = 0;
    mode_r       = POLICY_RST;
    cap_r        = MAX_OUT_RST;
    nodes_r      = NODES_RST;
    foreach (node_load[i]) node_load[i] = 4'd0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_zero_settings();
    test_first_fit_full_range();
    test_lowered_cap();
    test_random_phases(16, 60);
    test_backpressure();
    test_full_rate();

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/clld_pkg.sv
hw/rtl/clld_pick.sv
hw/rtl/capped_least_loaded_dispatcher.sv
tb/tb.sv
